[hw/rtl/swsr_pkg.sv]
// Package for the single-wire sensor reader: transaction structs, phase
// encoding, status codes, register indexes and register reset values.
// No dependencies; every other file of the block refers to it by scope.
`timescale 1ns / 1ps

package swsr_pkg;

  // Input transaction: one microsecond tick or a start request.
  typedef struct packed {
    logic func;
    logic line_level;
  } in_item_t;

  // Result transaction, one per accepted input transaction.
  typedef struct packed {
    logic        drive_enable;
    logic        drive_level;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [5:0]  bits_received;
    logic [15:0] humidity;
    logic signed [15:0] temperature;
  } result_t;

  // Configuration register file as seen by the sequencer.
  typedef struct packed {
    logic [23:0] pre_high_us;
    logic [23:0] start_low_us;
    logic [15:0] first_answer_timeout_us;
    logic [15:0] answer_timeout_us;
    logic [15:0] bit_timeout_us;
    logic [7:0]  one_threshold_us;
  } cfg_t;

  // Decoded frame, produced by the frame checker.
  typedef struct packed {
    logic        sum_ok;
    logic [15:0] humidity;
    logic [15:0] temperature;
  } frame_info_t;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b000_0001,
    PH_PRE_HIGH  = 7'b000_0010,
    PH_START_LOW = 7'b000_0100,
    PH_WAIT_LOW1 = 7'b000_1000,
    PH_WAIT_HIGH = 7'b001_0000,
    PH_WAIT_LOW2 = 7'b010_0000,
    PH_DATA      = 7'b100_0000
  } phase_t;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_ANSWER   = 3'd1;
  localparam logic [2:0] ST_HS_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_BIT_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_CHECKSUM    = 3'd4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PRE_HIGH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ANSWER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANSWER        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TIMEOUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 3'd5;

  localparam logic [23:0] PRE_HIGH_RST      = 24'd2000000;
  localparam logic [23:0] START_LOW_RST     = 24'd20000;
  localparam logic [15:0] FIRST_ANSWER_RST  = 16'd100;
  localparam logic [15:0] ANSWER_RST        = 16'd200;
  localparam logic [15:0] BIT_TIMEOUT_RST   = 16'd1000;
  localparam logic [7:0]  ONE_THRESHOLD_RST = 8'd40;

endpackage

[hw/rtl/swsr_frame.sv]
// Frame checker: byte-sum checksum and humidity/temperature extraction.
// Depends on swsr_pkg for the decoded frame struct.
`timescale 1ns / 1ps

module swsr_frame #(
  parameter int FRAME_BITS = 40
) (
  input  logic [FRAME_BITS-1:0] frame,
  output swsr_pkg::frame_info_t info
);

  logic [63:0] frame_wide;
  logic [7:0]  byte_sum;
  logic [15:0] temp_raw;
  logic [15:0] temp_mag;

  assign frame_wide = 64'(frame);

  // Every byte above the lowest one is summed; the lowest byte is the checksum.
  always_comb begin
    byte_sum = '0;
    for (int i = 1; i < 8; i++) begin
      if (8 * i < FRAME_BITS) begin
        byte_sum = byte_sum + frame_wide[8*i +: 8];
      end
    end
  end

  assign temp_raw = frame_wide[23:8];
  assign temp_mag = {1'b0, temp_raw[14:0]};

  always_comb begin
    info.sum_ok   = (byte_sum == frame_wide[7:0]);
    info.humidity = frame_wide[FRAME_BITS-16 +: 16];
    // Sign-magnitude to two's complement; negative zero comes out as zero.
    info.temperature = temp_raw[15] ? (16'd0 - temp_mag) : temp_mag;
  end

endmodule

[hw/rtl/swsr_core.sv]
// Read sequencer: phase register, tick timer, bit shifter and result values.
// Depends on swsr_pkg and instantiates swsr_frame.
`timescale 1ns / 1ps

module swsr_core #(
  parameter int FRAME_BITS  = 40,
  parameter int TIMER_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  swsr_pkg::in_item_t  item,
  input  swsr_pkg::cfg_t      cfg,
  output swsr_pkg::result_t   result
);

  localparam int CNT_W = $clog2(FRAME_BITS + 1);
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  swsr_pkg::phase_t        phase, phase_next;
  logic [TIMER_WIDTH-1:0]  elapsed, elapsed_next;
  logic                    prev_level, prev_level_next;
  logic [CNT_W-1:0]        bit_count, bit_count_next;
  logic [FRAME_BITS-1:0]   frame_shift, frame_shift_next;
  logic [15:0]             humidity, humidity_next;
  logic [15:0]             temperature, temperature_next;
  logic [2:0]              status, status_next;
  logic                    done;

  logic [TIMER_WIDTH-1:0]  elapsed_inc;
  logic [31:0]             tick32;
  logic                    want_level;
  logic [15:0]             wait_limit;
  logic [FRAME_BITS-1:0]   shifted;
  swsr_pkg::frame_info_t   info;

  assign elapsed_inc = (elapsed == TIMER_MAX) ? elapsed : elapsed + 1'b1;
  assign tick32      = 32'(elapsed_inc);
  assign want_level  = (phase == swsr_pkg::PH_WAIT_HIGH);
  assign wait_limit  = (phase == swsr_pkg::PH_WAIT_LOW1) ? cfg.first_answer_timeout_us
                                                         : cfg.answer_timeout_us;
  assign shifted     = {frame_shift[FRAME_BITS-2:0],
                        (tick32 > 32'(cfg.one_threshold_us))};

  swsr_frame #(.FRAME_BITS(FRAME_BITS)) u_frame (
    .frame (shifted),
    .info  (info)
  );

  always_comb begin
    phase_next       = phase;
    elapsed_next     = elapsed;
    prev_level_next  = prev_level;
    bit_count_next   = bit_count;
    frame_shift_next = frame_shift;
    humidity_next    = humidity;
    temperature_next = temperature;
    status_next      = status;
    done             = 1'b0;

    if (item.func == swsr_pkg::FUNC_START) begin
      if (phase == swsr_pkg::PH_IDLE) begin
        phase_next       = swsr_pkg::PH_PRE_HIGH;
        elapsed_next     = '0;
        bit_count_next   = '0;
        frame_shift_next = '0;
      end
    end else begin
      unique case (phase)
        swsr_pkg::PH_IDLE: begin
        end
        swsr_pkg::PH_PRE_HIGH: begin
          elapsed_next = elapsed_inc;
          if (tick32 >= 32'(cfg.pre_high_us)) begin
            phase_next   = swsr_pkg::PH_START_LOW;
            elapsed_next = '0;
          end
        end
        swsr_pkg::PH_START_LOW: begin
          elapsed_next = elapsed_inc;
          if (tick32 >= 32'(cfg.start_low_us)) begin
            phase_next   = swsr_pkg::PH_WAIT_LOW1;
            elapsed_next = '0;
          end
        end
        swsr_pkg::PH_WAIT_LOW1, swsr_pkg::PH_WAIT_HIGH, swsr_pkg::PH_WAIT_LOW2: begin
          if (item.line_level == want_level) begin
            elapsed_next = '0;
            if (phase == swsr_pkg::PH_WAIT_LOW1) begin
              phase_next = swsr_pkg::PH_WAIT_HIGH;
            end else if (phase == swsr_pkg::PH_WAIT_HIGH) begin
              phase_next = swsr_pkg::PH_WAIT_LOW2;
            end else begin
              phase_next       = swsr_pkg::PH_DATA;
              prev_level_next  = 1'b0;
              bit_count_next   = '0;
              frame_shift_next = '0;
            end
          end else begin
            elapsed_next = elapsed_inc;
            if (tick32 > 32'(wait_limit)) begin
              status_next = (phase == swsr_pkg::PH_WAIT_LOW1) ? swsr_pkg::ST_NO_ANSWER
                                                              : swsr_pkg::ST_HS_TIMEOUT;
              phase_next  = swsr_pkg::PH_IDLE;
              done        = 1'b1;
            end
          end
        end
        swsr_pkg::PH_DATA: begin
          elapsed_next = elapsed_inc;
          if (item.line_level == prev_level) begin
            if (tick32 > 32'(cfg.bit_timeout_us)) begin
              status_next = swsr_pkg::ST_BIT_TIMEOUT;
              phase_next  = swsr_pkg::PH_IDLE;
              done        = 1'b1;
            end
          end else begin
            if (!item.line_level) begin
              // Falling edge closes a high pulse: judge it and shift it in.
              frame_shift_next = shifted;
              bit_count_next   = bit_count + 1'b1;
              if (32'(bit_count) + 32'd1 >= 32'(FRAME_BITS)) begin
                phase_next = swsr_pkg::PH_IDLE;
                done       = 1'b1;
                if (info.sum_ok) begin
                  humidity_next    = info.humidity;
                  temperature_next = info.temperature;
                  status_next      = swsr_pkg::ST_OK;
                end else begin
                  status_next = swsr_pkg::ST_CHECKSUM;
                end
              end
            end
            elapsed_next    = '0;
            prev_level_next = item.line_level;
          end
        end
        default: begin
          phase_next = swsr_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result.drive_enable  = (phase_next == swsr_pkg::PH_PRE_HIGH) ||
                           (phase_next == swsr_pkg::PH_START_LOW);
    result.drive_level   = (phase_next == swsr_pkg::PH_PRE_HIGH);
    result.busy_res      = (phase_next != swsr_pkg::PH_IDLE);
    result.done_res      = done;
    result.status        = status_next;
    result.bits_received = 6'(bit_count_next);
    result.humidity      = humidity_next;
    result.temperature   = temperature_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= swsr_pkg::PH_IDLE;
      elapsed     <= '0;
      prev_level  <= 1'b0;
      bit_count   <= '0;
      frame_shift <= '0;
      humidity    <= '0;
      temperature <= '0;
      status      <= swsr_pkg::ST_OK;
    end else if (advance) begin
      phase       <= phase_next;
      elapsed     <= elapsed_next;
      prev_level  <= prev_level_next;
      bit_count   <= bit_count_next;
      frame_shift <= frame_shift_next;
      humidity    <= humidity_next;
      temperature <= temperature_next;
      status      <= status_next;
    end
  end

endmodule

[hw/rtl/swsr_out_buf.sv]
// Result buffer: output register plus one skid entry behind it.
// Depends on swsr_pkg for the result struct.
`timescale 1ns / 1ps

module swsr_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  swsr_pkg::result_t  push_data,
  output logic               has_room,
  output logic               out_valid,
  input  logic               out_ready,
  output swsr_pkg::result_t  out_data
);

  logic              skid_valid;
  swsr_pkg::result_t skid_data;
  logic              pop;

  assign pop      = out_valid && out_ready;
  assign has_room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid && pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && pop) begin
      out_data <= skid_data;
    end else if (push && (!out_valid || pop)) begin
      out_data <= push_data;
    end
    if (push && out_valid && !pop) begin
      skid_data <= push_data;
    end
  end

endmodule

[hw/rtl/single_wire_sensor_reader.sv]
// Top level of the single-wire humidity/temperature sensor reader.
// Depends on swsr_pkg; instantiates swsr_core and swsr_out_buf.
`timescale 1ns / 1ps

// How the block is used:
// The input channel (in_valid/in_ready/in_data) carries one transaction per
// microsecond tick with the sampled line level, or a start request. Every
// accepted input transaction yields exactly one result transaction on the
// output channel (out_valid/out_ready/out_data), showing the line drive, the
// busy and done flags, the status, the bit count and the last good humidity
// and temperature. The configuration channel (cfg_valid/cfg_ready/cfg_index/
// cfg_data) writes the timing registers; it is always ready. Software must
// write it only while no read is in progress; the block does not enforce this.
// An accepted transaction sits in the input register, then the sequencer
// updates its state and the result is registered. Throughput is one
// transaction per cycle while the output buffer has room, set by the single
// pass through the sequencer logic between those two registers.
// When the receiver stalls, the output register and a skid entry hold two
// results and the input register a third; only then does in_ready drop.
// Reset returns the sequencer and configuration registers to their defaults,
// the sequencer to idle and empties the pipeline. No clearing pass is needed.
module single_wire_sensor_reader #(
  parameter int FRAME_BITS  = 40,
  parameter int TIMER_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  swsr_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output swsr_pkg::result_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Input register in front of the sequencer.
  logic               in_q_valid;
  swsr_pkg::in_item_t in_q;

  logic               advance;
  logic               buf_room;
  swsr_pkg::result_t  core_result;
  swsr_pkg::cfg_t     cfg;

  // The sequencer steps whenever a transaction waits and the buffer can take
  // its result; the input register refills in the same cycle.
  assign advance   = in_q_valid && buf_room;
  assign in_ready  = !in_q_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // Configuration registers; data is cut to each register's width, and an
  // index outside the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pre_high_us             <= swsr_pkg::PRE_HIGH_RST;
      cfg.start_low_us            <= swsr_pkg::START_LOW_RST;
      cfg.first_answer_timeout_us <= swsr_pkg::FIRST_ANSWER_RST;
      cfg.answer_timeout_us       <= swsr_pkg::ANSWER_RST;
      cfg.bit_timeout_us          <= swsr_pkg::BIT_TIMEOUT_RST;
      cfg.one_threshold_us        <= swsr_pkg::ONE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swsr_pkg::REG_PRE_HIGH:      cfg.pre_high_us             <= cfg_data;
        swsr_pkg::REG_START_LOW:     cfg.start_low_us            <= cfg_data;
        swsr_pkg::REG_FIRST_ANSWER:  cfg.first_answer_timeout_us <= cfg_data[15:0];
        swsr_pkg::REG_ANSWER:        cfg.answer_timeout_us       <= cfg_data[15:0];
        swsr_pkg::REG_BIT_TIMEOUT:   cfg.bit_timeout_us          <= cfg_data[15:0];
        swsr_pkg::REG_ONE_THRESHOLD: cfg.one_threshold_us        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  swsr_core #(
    .FRAME_BITS  (FRAME_BITS),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_q),
    .cfg     (cfg),
    .result  (core_result)
  );

  swsr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (core_result),
    .has_room  (buf_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/swsr_checker.sv]
// Port-level checker for the sensor reader, bound to the top level.
// Depends on swsr_pkg for the transaction structs.
`timescale 1ns / 1ps

module swsr_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input swsr_pkg::result_t out_data
);

  // A stalled result transaction holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A read that just ended leaves the block idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res && !out_data.drive_enable)
    else $error("done reported while still busy");

  // The line is only driven high when the drive is enabled.
  a_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_level |-> out_data.drive_enable && out_data.busy_res)
    else $error("drive level without drive enable");

  // Nothing is in flight after reset, so no result can appear at once.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  // The input only stalls while results are waiting at the output.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind single_wire_sensor_reader swsr_checker u_swsr_checker (.*);
